@@ hw/rtl/set_statistics_unit_core_assert.svh @@
// ----------------------------------------------------------------------------
// Set statistics unit assertion macros
// Concurrent assertion wrappers on clk_i and rst_ni; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef SET_STATISTICS_UNIT_CORE_ASSERT_SVH
`define SET_STATISTICS_UNIT_CORE_ASSERT_SVH

`ifndef SYNTH

`define SSU_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("set statistics unit: same-cycle check failed");

`define SSU_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("set statistics unit: next-cycle check failed");

`else

`define SSU_ASSERT_IMP(lbl, pre, post)

`define SSU_ASSERT_NXT(lbl, pre, post)

`endif

`endif

@@ hw/rtl/ssu_pkg.sv @@
// ----------------------------------------------------------------------------
// Set statistics unit package
// Field widths, closing datapath widths and the result payload layout.
// ----------------------------------------------------------------------------
package ssu_pkg;

  localparam int unsigned MAX_COUNT_DEF = 256;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned MEAN_W   = 24;
  localparam int unsigned STD_W    = 23;

  localparam int unsigned IN_DATA_W  = SAMPLE_W + WEIGHT_W;
  localparam int unsigned OUT_DATA_W = 104;

  // closing datapath, sized for the largest set
  localparam int unsigned N_W     = 9;
  localparam int unsigned SUM_F_W = 25;
  localparam int unsigned SQ_F_W  = 39;
  localparam int unsigned WS_F_W  = 41;
  localparam int unsigned MAG_W   = 24;
  localparam int unsigned WMAG_W  = 40;
  localparam int unsigned T_W     = 47;
  localparam int unsigned X_W     = 63;
  localparam int unsigned ROOT_W  = 32;
  localparam int unsigned DIVD_W  = 48;
  localparam int unsigned DEN_W   = 24;
  localparam int unsigned MUL_W   = 26;
  localparam int unsigned SUB_W   = 64;
  localparam int unsigned ITER_W  = 6;
  localparam int unsigned SQ_LO_W = 25;

  localparam int unsigned DIV_STEPS_SHORT = 32;
  localparam int unsigned DIV_STEPS_LONG  = 48;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    PH_MEAN,
    PH_WMEAN,
    PH_STD
  } div_phase_e;

  // lowest bits first: mean, weighted mean, std dev, minimum, maximum, pad
  typedef struct packed {
    logic                       pad;
    logic signed [SAMPLE_W-1:0] maximum;
    logic signed [SAMPLE_W-1:0] minimum;
    logic        [STD_W-1:0]    std_dev_q8;
    logic signed [MEAN_W-1:0]   weighted_mean_q8;
    logic signed [MEAN_W-1:0]   mean_q8;
  } result_t;

endpackage

@@ hw/rtl/set_statistics_unit_core.sv @@
// ----------------------------------------------------------------------------
// Set statistics unit core
// Collects a set of weighted signed samples and, when the set closes on the
// item marked last or at MAX_COUNT samples, returns one result with the mean,
// weighted mean and population standard deviation in Q8 (truncated) plus the
// minimum and maximum; tuser flags a set whose weights sum to zero, and its
// weighted mean is then 0. An item that does not close its set goes through
// accept, then the square and the weight product, each on the shared
// 26x26 multiplier. The item that closes a set then takes four multiply and
// subtract steps, then on one shared 64-bit subtractor 32 steps of the
// digit-by-digit square root and restoring divisions of 32, 48 and 32 steps
// (no 48-step one when the weights sum to zero), then the output load, which
// waits until any held result is taken; input is taken again after that load.
// ----------------------------------------------------------------------------
`include "set_statistics_unit_core_assert.svh"

module set_statistics_unit_core #(
  parameter int unsigned MAX_COUNT = ssu_pkg::MAX_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // sample[15:0], weight[31:16]
  input  logic [ssu_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // mean_q8[23:0], weighted_mean_q8[47:24], std_dev_q8[70:48],
  // minimum[86:71], maximum[102:87], zero pad[103]
  output logic [ssu_pkg::OUT_DATA_W-1:0]  m_tdata,
  // no_weight[0]
  output logic                            m_tuser
);

  localparam int unsigned LOG_W  = $clog2(MAX_COUNT);
  localparam int unsigned CNT_W  = $clog2(MAX_COUNT + 1);
  localparam int unsigned SUM_W  = ssu_pkg::SAMPLE_W + 1 + LOG_W;
  localparam int unsigned SQ_W   = 2 * ssu_pkg::SAMPLE_W - 1 + LOG_W;
  localparam int unsigned WSUM_W = ssu_pkg::SAMPLE_W + ssu_pkg::WEIGHT_W + 1 + LOG_W;
  localparam int unsigned WTOT_W = ssu_pkg::WEIGHT_W + LOG_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ    = 4'd1;
  localparam logic [3:0] S_SW    = 4'd2;
  localparam logic [3:0] S_M0    = 4'd3;
  localparam logic [3:0] S_M1    = 4'd4;
  localparam logic [3:0] S_M2    = 4'd5;
  localparam logic [3:0] S_M3    = 4'd6;
  localparam logic [3:0] S_SQRT  = 4'd7;
  localparam logic [3:0] S_DLOAD = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state_q, state_d;

  logic signed [ssu_pkg::SAMPLE_W-1:0] s_q, s_d;
  logic        [ssu_pkg::WEIGHT_W-1:0] w_q, w_d;
  logic                                last_q, last_d;

  logic        [CNT_W-1:0]             cnt_q, cnt_d;
  logic signed [SUM_W-1:0]             sum_q, sum_d;
  logic        [SQ_W-1:0]              sq_q, sq_d;
  logic signed [WSUM_W-1:0]            wsum_q, wsum_d;
  logic        [WTOT_W-1:0]            wtot_q, wtot_d;
  logic signed [ssu_pkg::SAMPLE_W-1:0] min_q, min_d;
  logic signed [ssu_pkg::SAMPLE_W-1:0] max_q, max_d;

  logic [ssu_pkg::MAG_W-1:0]  mag_q, mag_d;
  logic                       neg_q, neg_d;
  logic [ssu_pkg::WMAG_W-1:0] wmag_q, wmag_d;
  logic                       wneg_q, wneg_d;
  logic [ssu_pkg::T_W-1:0]    t_q, t_d;
  logic [ssu_pkg::T_W-1:0]    p_q, p_d;
  logic [ssu_pkg::X_W-1:0]    x_q, x_d;
  logic [ssu_pkg::X_W-1:0]    root_q, root_d;
  logic [ssu_pkg::X_W-1:0]    bit_q, bit_d;

  ssu_pkg::div_phase_e          phase_q, phase_d;
  logic [ssu_pkg::DIVD_W-1:0]   dq_q, dq_d;
  logic [ssu_pkg::DEN_W-1:0]    rem_q, rem_d;
  logic [ssu_pkg::DEN_W-1:0]    den_q, den_d;
  logic [ssu_pkg::ITER_W-1:0]   iter_q, iter_d;

  logic signed [ssu_pkg::MEAN_W-1:0] mean_q, mean_d;
  logic signed [ssu_pkg::MEAN_W-1:0] wmean_q, wmean_d;
  logic                              nw_q, nw_d;

  ssu_pkg::result_t out_q, out_d;
  logic             ovalid_q, ovalid_d;
  logic             onw_q, onw_d;

  logic signed [ssu_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*ssu_pkg::MUL_W-1:0] mul_p;
  logic [ssu_pkg::SUB_W-1:0]          sub_a, sub_b;
  logic [ssu_pkg::SUB_W:0]            sub_r;
  logic                               sub_ge;

  logic signed [ssu_pkg::SAMPLE_W-1:0] s_in;
  logic [ssu_pkg::N_W-1:0]             n_ext;
  logic [ssu_pkg::SQ_F_W-1:0]          sq_ext;
  logic signed [ssu_pkg::SUM_F_W-1:0]  sum_f, sum_n;
  logic signed [ssu_pkg::WS_F_W-1:0]   ws_f, ws_n;
  logic [ssu_pkg::SUB_W-1:0]           rb_sum;
  logic [ssu_pkg::DIVD_W-1:0]          dq_next;
  logic [ssu_pkg::MEAN_W-1:0]          quo, quo_n;
  logic                                accept, closing;

  assign s_in    = $signed(s_tdata[ssu_pkg::SAMPLE_W-1:0]);
  assign accept  = s_tvalid && s_tready;
  assign closing = last_q || (cnt_q == CNT_W'(MAX_COUNT));
  assign n_ext   = ssu_pkg::N_W'(cnt_q);
  assign sq_ext  = ssu_pkg::SQ_F_W'(sq_q);
  assign sum_f   = ssu_pkg::SUM_F_W'(sum_q);
  assign sum_n   = -sum_f;
  assign ws_f    = ssu_pkg::WS_F_W'(wsum_q);
  assign ws_n    = -ws_f;
  assign rb_sum  = ssu_pkg::SUB_W'(root_q) + ssu_pkg::SUB_W'(bit_q);

  assign mul_p  = mul_a * mul_b;
  assign sub_r  = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge = !sub_r[ssu_pkg::SUB_W];

  assign dq_next = {dq_q[ssu_pkg::DIVD_W-2:0], sub_ge};
  assign quo     = dq_next[ssu_pkg::MEAN_W-1:0];
  assign quo_n   = ssu_pkg::MEAN_W'(0) - quo;

  assign s_tready = (state_q == S_IDLE);
  assign m_tvalid = ovalid_q;
  assign m_tdata  = out_q;
  assign m_tuser  = onw_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    sub_a = '0;
    sub_b = '0;
    case (state_q)
      S_SQ: begin
        mul_a = ssu_pkg::MUL_W'(s_q);
        mul_b = ssu_pkg::MUL_W'(s_q);
      end
      S_SW: begin
        mul_a = ssu_pkg::MUL_W'(s_q);
        mul_b = ssu_pkg::MUL_W'($signed({1'b0, w_q}));
      end
      S_M0: begin
        mul_a = ssu_pkg::MUL_W'($signed({1'b0, n_ext}));
        mul_b = ssu_pkg::MUL_W'($signed({1'b0, sq_ext[ssu_pkg::SQ_LO_W-1:0]}));
      end
      S_M1: begin
        mul_a = ssu_pkg::MUL_W'($signed({1'b0, n_ext}));
        mul_b = ssu_pkg::MUL_W'($signed({1'b0, sq_ext[ssu_pkg::SQ_F_W-1:ssu_pkg::SQ_LO_W]}));
      end
      S_M2: begin
        mul_a = ssu_pkg::MUL_W'($signed({1'b0, mag_q}));
        mul_b = ssu_pkg::MUL_W'($signed({1'b0, mag_q}));
      end
      S_M3: begin
        sub_a = ssu_pkg::SUB_W'(t_q);
        sub_b = ssu_pkg::SUB_W'(p_q);
      end
      S_SQRT: begin
        sub_a = ssu_pkg::SUB_W'(x_q);
        sub_b = rb_sum;
      end
      S_DIV: begin
        sub_a = ssu_pkg::SUB_W'({rem_q, dq_q[ssu_pkg::DIVD_W-1]});
        sub_b = ssu_pkg::SUB_W'(den_q);
      end
      default: begin
        sub_a = '0;
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    s_d      = s_q;
    w_d      = w_q;
    last_d   = last_q;
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    sq_d     = sq_q;
    wsum_d   = wsum_q;
    wtot_d   = wtot_q;
    min_d    = min_q;
    max_d    = max_q;
    mag_d    = mag_q;
    neg_d    = neg_q;
    wmag_d   = wmag_q;
    wneg_d   = wneg_q;
    t_d      = t_q;
    p_d      = p_q;
    x_d      = x_q;
    root_d   = root_q;
    bit_d    = bit_q;
    phase_d  = phase_q;
    dq_d     = dq_q;
    rem_d    = rem_q;
    den_d    = den_q;
    iter_d   = iter_q;
    mean_d   = mean_q;
    wmean_d  = wmean_q;
    nw_d     = nw_q;
    out_d    = out_q;
    onw_d    = onw_q;
    ovalid_d = ovalid_q && !m_tready;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          s_d    = s_in;
          w_d    = s_tdata[ssu_pkg::IN_DATA_W-1:ssu_pkg::SAMPLE_W];
          last_d = s_tlast;
          cnt_d  = cnt_q + CNT_W'(1);
          sum_d  = sum_q + SUM_W'(s_in);
          wtot_d = wtot_q + WTOT_W'(s_tdata[ssu_pkg::IN_DATA_W-1:ssu_pkg::SAMPLE_W]);
          if (s_in < min_q) begin
            min_d = s_in;
          end
          if (s_in > max_q) begin
            max_d = s_in;
          end
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        sq_d    = sq_q + SQ_W'(mul_p[2*ssu_pkg::SAMPLE_W-2:0]);
        state_d = S_SW;
      end
      S_SW: begin
        wsum_d = wsum_q + WSUM_W'($signed(mul_p[2*ssu_pkg::SAMPLE_W-1:0]));
        if (closing) begin
          neg_d   = sum_f[ssu_pkg::SUM_F_W-1];
          mag_d   = sum_f[ssu_pkg::SUM_F_W-1] ? sum_n[ssu_pkg::MAG_W-1:0]
                                               : sum_f[ssu_pkg::MAG_W-1:0];
          state_d = S_M0;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_M0: begin
        wneg_d  = ws_f[ssu_pkg::WS_F_W-1];
        wmag_d  = ws_f[ssu_pkg::WS_F_W-1] ? ws_n[ssu_pkg::WMAG_W-1:0]
                                          : ws_f[ssu_pkg::WMAG_W-1:0];
        t_d     = mul_p[ssu_pkg::T_W-1:0];
        state_d = S_M1;
      end
      S_M1: begin
        t_d     = t_q + {mul_p[ssu_pkg::T_W-ssu_pkg::SQ_LO_W-1:0],
                         {ssu_pkg::SQ_LO_W{1'b0}}};
        state_d = S_M2;
      end
      S_M2: begin
        p_d     = mul_p[ssu_pkg::T_W-1:0];
        state_d = S_M3;
      end
      S_M3: begin
        x_d     = {sub_r[ssu_pkg::T_W-1:0], {(ssu_pkg::X_W-ssu_pkg::T_W){1'b0}}};
        root_d  = '0;
        bit_d   = ssu_pkg::X_W'(1) << (ssu_pkg::X_W - 1);
        state_d = S_SQRT;
      end
      S_SQRT: begin
        if (sub_ge) begin
          x_d    = sub_r[ssu_pkg::X_W-1:0];
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          phase_d = ssu_pkg::PH_MEAN;
          state_d = S_DLOAD;
        end
      end
      S_DLOAD: begin
        rem_d   = '0;
        state_d = S_DIV;
        case (phase_q)
          ssu_pkg::PH_MEAN: begin
            dq_d   = {mag_q, 8'b0, {(ssu_pkg::DIVD_W-ssu_pkg::DIV_STEPS_SHORT){1'b0}}};
            den_d  = ssu_pkg::DEN_W'(n_ext);
            iter_d = ssu_pkg::ITER_W'(ssu_pkg::DIV_STEPS_SHORT - 1);
          end
          ssu_pkg::PH_WMEAN: begin
            nw_d   = (wtot_q == '0);
            dq_d   = {wmag_q, 8'b0};
            den_d  = ssu_pkg::DEN_W'(wtot_q);
            iter_d = ssu_pkg::ITER_W'(ssu_pkg::DIV_STEPS_LONG - 1);
            if (wtot_q == '0) begin
              wmean_d = '0;
              phase_d = ssu_pkg::PH_STD;
              state_d = S_DLOAD;
            end
          end
          default: begin
            dq_d   = {root_q[ssu_pkg::ROOT_W-1:0],
                      {(ssu_pkg::DIVD_W-ssu_pkg::ROOT_W){1'b0}}};
            den_d  = ssu_pkg::DEN_W'(n_ext);
            iter_d = ssu_pkg::ITER_W'(ssu_pkg::DIV_STEPS_SHORT - 1);
          end
        endcase
      end
      S_DIV: begin
        rem_d  = sub_ge ? sub_r[ssu_pkg::DEN_W-1:0]
                        : {rem_q[ssu_pkg::DEN_W-2:0], dq_q[ssu_pkg::DIVD_W-1]};
        dq_d   = dq_next;
        iter_d = iter_q - ssu_pkg::ITER_W'(1);
        if (iter_q == '0) begin
          case (phase_q)
            ssu_pkg::PH_MEAN: begin
              mean_d  = neg_q ? $signed(quo_n) : $signed(quo);
              phase_d = ssu_pkg::PH_WMEAN;
              state_d = S_DLOAD;
            end
            ssu_pkg::PH_WMEAN: begin
              wmean_d = wneg_q ? $signed(quo_n) : $signed(quo);
              phase_d = ssu_pkg::PH_STD;
              state_d = S_DLOAD;
            end
            default: begin
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_OUT: begin
        if (!ovalid_q || m_tready) begin
          out_d.pad              = 1'b0;
          out_d.maximum          = max_q;
          out_d.minimum          = min_q;
          out_d.std_dev_q8       = dq_q[ssu_pkg::STD_W-1:0];
          out_d.weighted_mean_q8 = wmean_q;
          out_d.mean_q8          = mean_q;
          onw_d    = nw_q;
          ovalid_d = 1'b1;
          cnt_d    = '0;
          sum_d    = '0;
          sq_d     = '0;
          wsum_d   = '0;
          wtot_d   = '0;
          min_d    = ssu_pkg::SAMPLE_MAX;
          max_d    = ssu_pkg::SAMPLE_MIN;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      sum_q    <= '0;
      sq_q     <= '0;
      wsum_q   <= '0;
      wtot_q   <= '0;
      min_q    <= ssu_pkg::SAMPLE_MAX;
      max_q    <= ssu_pkg::SAMPLE_MIN;
      phase_q  <= ssu_pkg::PH_MEAN;
      iter_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      sum_q    <= sum_d;
      sq_q     <= sq_d;
      wsum_q   <= wsum_d;
      wtot_q   <= wtot_d;
      min_q    <= min_d;
      max_q    <= max_d;
      phase_q  <= phase_d;
      iter_q   <= iter_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q     <= s_d;
    w_q     <= w_d;
    last_q  <= last_d;
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    wmag_q  <= wmag_d;
    wneg_q  <= wneg_d;
    t_q     <= t_d;
    p_q     <= p_d;
    x_q     <= x_d;
    root_q  <= root_d;
    bit_q   <= bit_d;
    dq_q    <= dq_d;
    rem_q   <= rem_d;
    den_q   <= den_d;
    mean_q  <= mean_d;
    wmean_q <= wmean_d;
    nw_q    <= nw_d;
    out_q   <= out_d;
    onw_q   <= onw_d;
  end

  `SSU_ASSERT_IMP(a_rem_below_den, state_q == S_DIV, rem_q < den_q)
  `SSU_ASSERT_NXT(a_accept_to_square, accept, state_q == S_SQ)
  `SSU_ASSERT_IMP(a_set_cleared, $rose(ovalid_q), cnt_q == '0 && state_q == S_IDLE)

endmodule
